### src/mge_pkg.sv
// shared constants, types and event codes for the mouse gesture event generator
// no dependencies
`default_nettype none

package mge_pkg;

   localparam int COORD_BITS    = 12;
   localparam int BUTTON_COUNT  = 3;
   localparam int MOVE_BITS     = 9;
   localparam int WHEEL_BITS    = 8;
   localparam int TIME_BITS     = 32;
   localparam int WINDOW_BITS   = 16;
   localparam int SLOP_BITS     = 8;
   localparam int KIND_BITS     = 3;
   localparam int BTN_BITS      = 2;
   localparam int MASK_BITS     = 3;
   localparam int LEVEL_BITS    = 3;

   // one wheel slot, one move slot, then per button: down/up, click, double click
   localparam int SLOT_COUNT    = 2 + 3 * BUTTON_COUNT;
   localparam int SLOT_BITS     = $clog2(SLOT_COUNT);

   localparam int REQ_FIELD_BITS = 2 * MOVE_BITS + WHEEL_BITS + LEVEL_BITS + TIME_BITS;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = 2 * COORD_BITS + 2 * MOVE_BITS + WHEEL_BITS + BTN_BITS
                                   + MASK_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCREEN_MAX_X = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCREEN_MAX_Y = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DBL_WINDOW   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CLICK_SLOP   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DBL_DISTANCE = 3'd4;

   localparam logic [KIND_BITS-1:0] EVT_WHEEL  = 3'd0;
   localparam logic [KIND_BITS-1:0] EVT_MOVE   = 3'd1;
   localparam logic [KIND_BITS-1:0] EVT_DRAG   = 3'd2;
   localparam logic [KIND_BITS-1:0] EVT_DOWN   = 3'd3;
   localparam logic [KIND_BITS-1:0] EVT_UP     = 3'd4;
   localparam logic [KIND_BITS-1:0] EVT_CLICK  = 3'd5;
   localparam logic [KIND_BITS-1:0] EVT_DOUBLE = 3'd6;

   localparam int SLOT_WHEEL = 0;
   localparam int SLOT_MOVE  = 1;
   localparam int SLOT_BTN0  = 2;

   typedef logic [COORD_BITS-1:0] coord_type;

   localparam coord_type RESET_MAX_X = coord_type'(1023);
   localparam coord_type RESET_MAX_Y = coord_type'(767);
   localparam coord_type RESET_POS_X = RESET_MAX_X >> 1;
   localparam coord_type RESET_POS_Y = RESET_MAX_Y >> 1;
   localparam logic [WINDOW_BITS-1:0] RESET_WINDOW   = 16'd400;
   localparam logic [SLOP_BITS-1:0]   RESET_SLOP     = 8'd4;
   localparam logic [SLOP_BITS-1:0]   RESET_DISTANCE = 8'd6;

   typedef struct packed {
      coord_type                max_x;
      coord_type                max_y;
      logic [WINDOW_BITS-1:0]   window;
      logic [SLOP_BITS-1:0]     slop;
      logic [SLOP_BITS-1:0]     distance;
   } cfg_type;

   // everything the emitter needs to send the events of one packet
   typedef struct packed {
      logic [SLOT_COUNT-1:0]          slots;
      logic [BUTTON_COUNT-1:0]        down;
      coord_type                      old_x;
      coord_type                      old_y;
      coord_type                      new_x;
      coord_type                      new_y;
      logic [MASK_BITS-1:0]           old_mask;
      logic [MASK_BITS-1:0]           new_mask;
      logic signed [MOVE_BITS-1:0]    dx;
      logic signed [MOVE_BITS-1:0]    dy;
      logic signed [WHEEL_BITS-1:0]   wheel;
   } pkt_type;

endpackage

`default_nettype wire

### src/mge_csr.sv
// configuration registers of the mouse gesture event generator
// depends on mge_pkg
`default_nettype none

module mge_csr
   import mge_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_wr_en,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output      cfg_type                   cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SCREEN_MAX_X: cfg_in.max_x    = csr_wdata[COORD_BITS-1:0];
            CSR_SCREEN_MAX_Y: cfg_in.max_y    = csr_wdata[COORD_BITS-1:0];
            CSR_DBL_WINDOW:   cfg_in.window   = csr_wdata[WINDOW_BITS-1:0];
            CSR_CLICK_SLOP:   cfg_in.slop     = csr_wdata[SLOP_BITS-1:0];
            CSR_DBL_DISTANCE: cfg_in.distance = csr_wdata[SLOP_BITS-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_x    <= RESET_MAX_X;
         cfg_ff.max_y    <= RESET_MAX_Y;
         cfg_ff.window   <= RESET_WINDOW;
         cfg_ff.slop     <= RESET_SLOP;
         cfg_ff.distance <= RESET_DISTANCE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### src/mge_core.sv
// input register, cursor and button state, and per-packet event decision
// depends on mge_pkg
`default_nettype none

module mge_core
   import mge_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output      logic                     req_tready,
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,
   input  wire cfg_type                  cfg,
   input  wire logic                     emit_free,
   output      logic                     pkt_load,
   output      pkt_type                  pkt
);

   localparam int SUM_BITS = COORD_BITS + 2;

   function automatic coord_type clamp_axis(coord_type pos, logic signed [MOVE_BITS-1:0] d,
                                            coord_type lim);
      logic signed [SUM_BITS-1:0] sum;
      sum = $signed({2'b00, pos}) + SUM_BITS'(d);
      if (sum < 0) begin
         return '0;
      end else if (sum > $signed({2'b00, lim})) begin
         return lim;
      end
      return sum[COORD_BITS-1:0];
   endfunction

   function automatic coord_type abs_diff(coord_type a, coord_type b);
      return (a >= b) ? coord_type'(a - b) : coord_type'(b - a);
   endfunction

   logic                      in_valid_ff, in_valid_in;
   logic [REQ_DATA_BITS-1:0]  in_data_ff;
   logic                      commit;

   logic signed [MOVE_BITS-1:0]  dx, dy;
   logic signed [WHEEL_BITS-1:0] wheel;
   logic [LEVEL_BITS-1:0]        levels;
   logic [TIME_BITS-1:0]         now;
   logic [BUTTON_COUNT-1:0]      nb, changed, down, up, click, dbl;
   logic                         moved;

   coord_type                 pos_x_ff, pos_y_ff, new_x, new_y;
   logic [BUTTON_COUNT-1:0]   held_ff;
   logic [SLOT_COUNT-1:0]     slots;

   assign dx     = in_data_ff[MOVE_BITS-1:0];
   assign dy     = in_data_ff[2*MOVE_BITS-1:MOVE_BITS];
   assign wheel  = in_data_ff[2*MOVE_BITS+WHEEL_BITS-1:2*MOVE_BITS];
   assign levels = in_data_ff[2*MOVE_BITS+WHEEL_BITS+LEVEL_BITS-1:2*MOVE_BITS+WHEEL_BITS];
   assign now    = in_data_ff[REQ_FIELD_BITS-1:2*MOVE_BITS+WHEEL_BITS+LEVEL_BITS];

   assign nb      = levels[BUTTON_COUNT-1:0];
   assign moved   = (dx != '0) || (dy != '0);
   assign new_x   = moved ? clamp_axis(pos_x_ff, dx, cfg.max_x) : pos_x_ff;
   assign new_y   = moved ? clamp_axis(pos_y_ff, dy, cfg.max_y) : pos_y_ff;
   assign changed = held_ff ^ nb;
   assign down    = changed & nb;
   assign up      = changed & ~nb;

   assign commit      = in_valid_ff && emit_free;
   assign req_tready  = !in_valid_ff || emit_free;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff <= RESET_POS_X;
         pos_y_ff <= RESET_POS_Y;
         held_ff  <= '0;
      end else if (commit) begin
         pos_x_ff <= new_x;
         pos_y_ff <= new_y;
         held_ff  <= nb;
      end
   end

   for (genvar b = 0; b < BUTTON_COUNT; b++) begin : g_button
      coord_type              press_x_ff, press_y_ff, click_x_ff, click_y_ff;
      logic [TIME_BITS-1:0]   click_time_ff;
      logic [TIME_BITS-1:0]   elapsed;
      logic                   pending_ff;

      assign elapsed  = now - click_time_ff;
      assign click[b] = up[b]
                        && (abs_diff(new_x, press_x_ff) <= COORD_BITS'(cfg.slop))
                        && (abs_diff(new_y, press_y_ff) <= COORD_BITS'(cfg.slop));
      assign dbl[b]   = click[b] && pending_ff
                        && (elapsed <= TIME_BITS'(cfg.window))
                        && (abs_diff(new_x, click_x_ff) <= COORD_BITS'(cfg.distance))
                        && (abs_diff(new_y, click_y_ff) <= COORD_BITS'(cfg.distance));

      always_ff @(posedge clock) begin
         if (reset) begin
            pending_ff <= 1'b0;
         end else if (commit && click[b]) begin
            pending_ff <= !dbl[b];
         end
      end

      always_ff @(posedge clock) begin
         if (commit && down[b]) begin
            press_x_ff <= new_x;
            press_y_ff <= new_y;
         end
         if (commit && click[b] && !dbl[b]) begin
            click_time_ff <= now;
            click_x_ff    <= new_x;
            click_y_ff    <= new_y;
         end
      end

      assign slots[SLOT_BTN0+3*b]   = changed[b];
      assign slots[SLOT_BTN0+3*b+1] = click[b];
      assign slots[SLOT_BTN0+3*b+2] = dbl[b];
   end

   assign slots[SLOT_WHEEL] = (wheel != '0);
   assign slots[SLOT_MOVE]  = moved;

   assign pkt_load     = commit;
   assign pkt.slots    = slots;
   assign pkt.down     = down;
   assign pkt.old_x    = pos_x_ff;
   assign pkt.old_y    = pos_y_ff;
   assign pkt.new_x    = new_x;
   assign pkt.new_y    = new_y;
   assign pkt.old_mask = MASK_BITS'(held_ff);
   assign pkt.new_mask = MASK_BITS'(nb);
   assign pkt.dx       = dx;
   assign pkt.dy       = dy;
   assign pkt.wheel    = wheel;

endmodule

`default_nettype wire

### src/mge_emit.sv
// packet event list, one beat per cycle via the result register unless stalled
// depends on mge_pkg
`default_nettype none

module mge_emit
   import mge_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     pkt_load,
   input  wire pkt_type                  pkt,
   output      logic                     emit_free,
   output      logic                     rsp_tvalid,
   input  wire logic                     rsp_tready,
   output      logic [RSP_DATA_BITS-1:0] rsp_tdata,
   output      logic [KIND_BITS-1:0]     rsp_tuser,
   output      logic                     rsp_tlast
);

   logic [SLOT_COUNT-1:0]     pending_ff, pending_in, first, rest;
   pkt_type                   pkt_ff;
   logic [SLOT_BITS-1:0]      idx;
   logic                      out_load;

   logic                      valid_ff, valid_in;
   logic [RSP_DATA_BITS-1:0]  data_ff, data_in;
   logic [KIND_BITS-1:0]      kind_ff, kind_in;
   logic                      last_ff;

   coord_type                    cx, cy;
   logic signed [MOVE_BITS-1:0]  ex, ey;
   logic signed [WHEEL_BITS-1:0] ew;
   logic [BTN_BITS-1:0]          btn;
   logic [MASK_BITS-1:0]         mask;

   assign first = pending_ff & (~pending_ff + 1'b1);
   assign rest  = pending_ff & ~first;

   always_comb begin
      idx = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (first[i]) begin
            idx = SLOT_BITS'(i);
         end
      end
   end

   assign out_load  = (pending_ff != '0) && (!valid_ff || rsp_tready);
   assign emit_free = (pending_ff == '0) || (out_load && (rest == '0));

   always_comb begin
      kind_in = EVT_MOVE;
      cx      = pkt_ff.new_x;
      cy      = pkt_ff.new_y;
      ex      = '0;
      ey      = '0;
      ew      = '0;
      btn     = '0;
      mask    = pkt_ff.new_mask;
      if (idx == SLOT_BITS'(SLOT_WHEEL)) begin
         kind_in = EVT_WHEEL;
         cx      = pkt_ff.old_x;
         cy      = pkt_ff.old_y;
         ew      = pkt_ff.wheel;
         mask    = pkt_ff.old_mask;
      end else if (idx == SLOT_BITS'(SLOT_MOVE)) begin
         kind_in = (pkt_ff.new_mask != '0) ? EVT_DRAG : EVT_MOVE;
         ex      = pkt_ff.dx;
         ey      = pkt_ff.dy;
      end
      for (int b = 0; b < BUTTON_COUNT; b++) begin
         if (idx == SLOT_BITS'(SLOT_BTN0 + 3 * b)) begin
            kind_in = pkt_ff.down[b] ? EVT_DOWN : EVT_UP;
            btn     = BTN_BITS'(b);
         end else if (idx == SLOT_BITS'(SLOT_BTN0 + 3 * b + 1)) begin
            kind_in = EVT_CLICK;
            btn     = BTN_BITS'(b);
         end else if (idx == SLOT_BITS'(SLOT_BTN0 + 3 * b + 2)) begin
            kind_in = EVT_DOUBLE;
            btn     = BTN_BITS'(b);
         end
      end
      data_in = RSP_DATA_BITS'({mask, btn, ew, ey, ex, cy, cx});
   end

   always_comb begin
      pending_in = pending_ff;
      if (pkt_load) begin
         pending_in = pkt.slots;
      end else if (out_load) begin
         pending_in = rest;
      end
   end

   assign valid_in = out_load ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         valid_ff   <= 1'b0;
      end else begin
         pending_ff <= pending_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pkt_load) begin
         pkt_ff <= pkt;
      end
      if (out_load) begin
         data_ff <= data_in;
         kind_ff <= kind_in;
         last_ff <= (rest == '0);
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

endmodule

`default_nettype wire

### src/mouse_gesture_event_generator.sv
// mouse gesture event generator: a taken beat passes the input, packet and result
// registers before its first event; a packet yields up to 11 events, sent one beat
// per cycle unless rsp_tready stalls, and the next packet loads as the last one leaves
// synchronous active-high reset restores the configured limits and timing defaults,
// centers the cursor, releases all buttons and clears pending clicks
`default_nettype none

module mouse_gesture_event_generator
   import mge_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   // move_x, move_y, wheel_step, left_held, right_held, middle_held, time_ms, zero pad
   input  wire logic [REQ_DATA_BITS-1:0]  req_tdata,
   input  wire logic                      req_tvalid,
   output      logic                      req_tready,
   // cursor_x, cursor_y, delta_x, delta_y, wheel_amount, which_button, button_mask, zero pad
   output      logic [RSP_DATA_BITS-1:0]  rsp_tdata,
   // event_kind
   output      logic [KIND_BITS-1:0]      rsp_tuser,
   output      logic                      rsp_tlast,
   output      logic                      rsp_tvalid,
   input  wire logic                      rsp_tready,
   input  wire logic                      csr_wr_en,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   cfg_type cfg;
   pkt_type pkt;
   logic    pkt_load;
   logic    emit_free;

   mge_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mge_core u_core (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .cfg        (cfg),
      .emit_free  (emit_free),
      .pkt_load   (pkt_load),
      .pkt        (pkt)
   );

   mge_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .pkt_load   (pkt_load),
      .pkt        (pkt),
      .emit_free  (emit_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   localparam int DX_LO = 2 * COORD_BITS;
   localparam int MSK_LO = 2 * COORD_BITS + 2 * MOVE_BITS + WHEEL_BITS + BTN_BITS;

   a_move_no_buttons: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == EVT_MOVE) |-> rsp_tdata[MSK_LO+MASK_BITS-1:MSK_LO] == '0)
      else $error("move event with buttons held");

   a_drag_has_buttons: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == EVT_DRAG) |-> rsp_tdata[MSK_LO+MASK_BITS-1:MSK_LO] != '0)
      else $error("drag event without buttons");

   a_delta_only_on_motion: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != EVT_MOVE) && (rsp_tuser != EVT_DRAG)
      |-> rsp_tdata[DX_LO+2*MOVE_BITS-1:DX_LO] == '0)
      else $error("movement carried by a non-motion event");

   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      pkt_load |-> emit_free)
      else $error("packet loaded over unsent events");

endmodule

`default_nettype wire
